### rtl/core/atd_pkg.sv
// package for the accelerometer tilt detector: widths, register indexes,
// the arcsine table and the structs passed between lanes and merge stage
// no dependencies
`timescale 1ns / 1ps

package atd_pkg;

   localparam int ACC_W      = 15;
   localparam int TIME_W     = 32;
   localparam int ANG_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int THR_W      = 14;
   localparam int DUR_W      = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;
   localparam int LANE_LAT   = 6;

   localparam int MG_FULL_SCALE_DEFAULT = 1000;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
   localparam logic [THR_W-1:0]  THR_RESET  = 14'd2502;
   localparam logic [DUR_W-1:0]  DUR_RESET  = 16'd1000;

   localparam int ASIN_STEPS = 32;
   localparam int IDX_W      = 6;
   localparam int MAG_W      = 13;
   localparam int DIFF_W     = 11;

   localparam logic [MAG_W-1:0] HALF_PI_Q12 = 13'd6434;

   localparam logic [MAG_W-1:0] ASIN_TAB [0:ASIN_STEPS] = '{
      13'd0,    13'd128,  13'd256,  13'd385,  13'd513,  13'd643,  13'd773,
      13'd903,  13'd1035, 13'd1168, 13'd1302, 13'd1437, 13'd1574, 13'd1714,
      13'd1855, 13'd1998, 13'd2145, 13'd2294, 13'd2447, 13'd2604, 13'd2765,
      13'd2932, 13'd3105, 13'd3285, 13'd3474, 13'd3673, 13'd3885, 13'd4113,
      13'd4364, 13'd4646, 13'd4978, 13'd5407, 13'd6434
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FILTER_GAIN   = 2'd0,
      REG_TILT_THRESH   = 2'd1,
      REG_TILT_DURATION = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] filt;
      logic signed [ANG_W-1:0] ang;
   } lane_out_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic              batch_end;
   } side_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [DUR_W-1:0] duration;
   } tilt_cfg_type;

endpackage

### rtl/core/atd_lane.sv
// one axis lane: low-pass filter, clamp, table interpolated arcsine
// (or arccosine) over six register stages
// depends on atd_pkg
`timescale 1ns / 1ps

module atd_lane #(
   parameter int MG_FULL_SCALE = atd_pkg::MG_FULL_SCALE_DEFAULT,
   parameter bit IS_ACOS       = 1'b0
) (
   input  logic                                 clock,
   input  logic [atd_pkg::LANE_LAT-1:0]         ld,
   input  logic                                 seeded,
   input  logic [atd_pkg::GAIN_W-1:0]           gain,
   input  logic signed [atd_pkg::ACC_W-1:0]     accel,
   output atd_pkg::lane_out_type                lane_out
);

   localparam int FS  = MG_FULL_SCALE;
   localparam int AW  = $clog2(FS + 1);
   localparam int SHW = $clog2(atd_pkg::ASIN_STEPS);
   localparam int PW  = AW + SHW;
   localparam int K1  = PW;
   localparam int RW  = $clog2(FS);
   localparam int TW  = atd_pkg::DIFF_W + RW;
   localparam logic [K1-1:0] M1 = K1'((1 << K1) / FS);
   localparam logic [TW-1:0] M2 = TW'((1 << TW) / FS);
   localparam int AC  = atd_pkg::ACC_W;
   localparam int IW  = atd_pkg::IDX_W;
   localparam int MW  = atd_pkg::MAG_W;
   localparam int DW  = atd_pkg::DIFF_W;
   localparam int NW  = atd_pkg::ANG_W;

   // stage 0: filter state
   logic signed [AC-1:0]     filt_ff;
   logic signed [AC-1:0]     old_val;
   logic signed [AC:0]       delta;
   logic signed [AC+17:0]    wprod;
   logic signed [AC+18:0]    num;
   logic signed [AC+18:0]    num_adj;
   logic signed [AC-1:0]     filt_in;

   always_comb begin
      old_val = seeded ? filt_ff : accel;
      delta   = {accel[AC-1], accel} - {old_val[AC-1], old_val};
      wprod   = $signed({1'b0, gain}) * delta;
      num     = {{3{old_val[AC-1]}}, old_val, 16'b0} + {wprod[AC+17], wprod};
      num_adj = num[AC+18] ? num + (AC+19)'(65535) : num;
      filt_in = num_adj[AC+15:16];
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         filt_ff <= filt_in;
      end
   end

   // stage 1: magnitude, clamp, reciprocal product for the table index
   logic [AC-1:0]      mag_abs;
   logic [AW-1:0]      clamp_in;
   logic [PW-1:0]      p_in;
   logic [PW+K1-1:0]   prod1_in;
   logic [PW-1:0]      p_ff;
   logic [PW+K1-1:0]   prod1_ff;
   logic               neg1_ff;
   logic signed [AC-1:0] filt1_ff;

   always_comb begin
      mag_abs  = filt_ff[AC-1] ? (~filt_ff + AC'(1)) : filt_ff;
      clamp_in = (mag_abs > AC'(FS)) ? AW'(FS) : AW'(mag_abs);
      p_in     = {clamp_in, SHW'(0)};
      prod1_in = (PW+K1)'(p_in) * (PW+K1)'(M1);
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         p_ff     <= p_in;
         prod1_ff <= prod1_in;
         neg1_ff  <= filt_ff[AC-1];
         filt1_ff <= filt_ff;
      end
   end

   // stage 2: index and remainder with one correction step
   logic [IW-1:0]  q1;
   logic [PW-1:0]  q1fs;
   logic [PW-1:0]  r1;
   logic [IW-1:0]  idx_in;
   logic [RW-1:0]  rem_in;
   logic [IW-1:0]  idx_ff;
   logic [RW-1:0]  rem_ff;
   logic           neg2_ff;
   logic signed [AC-1:0] filt2_ff;

   always_comb begin
      q1   = IW'(prod1_ff >> K1);
      q1fs = PW'(PW'(q1) * PW'(FS));
      r1   = p_ff - q1fs;
      if (r1 >= PW'(FS)) begin
         idx_in = q1 + IW'(1);
         rem_in = RW'(r1 - PW'(FS));
      end else begin
         idx_in = q1;
         rem_in = RW'(r1);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         idx_ff   <= idx_in;
         rem_ff   <= rem_in;
         neg2_ff  <= neg1_ff;
         filt2_ff <= filt1_ff;
      end
   end

   // stage 3: table lookup and slope times remainder
   logic [IW-1:0]  idx_nxt;
   logic [MW-1:0]  base_in;
   logic [DW-1:0]  slope;
   logic [TW-1:0]  t_in;
   logic [MW-1:0]  base3_ff;
   logic [TW-1:0]  t3_ff;
   logic           neg3_ff;
   logic signed [AC-1:0] filt3_ff;

   always_comb begin
      idx_nxt = (idx_ff == IW'(atd_pkg::ASIN_STEPS)) ? idx_ff : idx_ff + IW'(1);
      base_in = atd_pkg::ASIN_TAB[idx_ff];
      slope   = DW'(atd_pkg::ASIN_TAB[idx_nxt] - base_in);
      t_in    = TW'(slope) * TW'(rem_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         base3_ff <= base_in;
         t3_ff    <= t_in;
         neg3_ff  <= neg2_ff;
         filt3_ff <= filt2_ff;
      end
   end

   // stage 4: reciprocal product for the interpolation step
   logic [2*TW-1:0] prod2_in;
   logic [2*TW-1:0] prod2_ff;
   logic [MW-1:0]   base4_ff;
   logic [TW-1:0]   t4_ff;
   logic            neg4_ff;
   logic signed [AC-1:0] filt4_ff;

   assign prod2_in = (2*TW)'(t3_ff) * (2*TW)'(M2);

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         prod2_ff <= prod2_in;
         base4_ff <= base3_ff;
         t4_ff    <= t3_ff;
         neg4_ff  <= neg3_ff;
         filt4_ff <= filt3_ff;
      end
   end

   // stage 5: quotient correction, sign and arccosine fold
   logic [DW-1:0]  q2;
   logic [DW-1:0]  q2c;
   logic [TW-1:0]  q2fs;
   logic [TW-1:0]  r2;
   logic [MW-1:0]  mag_ang;
   logic [NW-1:0]  sang;
   logic [NW-1:0]  ang_in;
   atd_pkg::lane_out_type out_ff;

   always_comb begin
      q2      = DW'(prod2_ff >> TW);
      q2fs    = TW'(TW'(q2) * TW'(FS));
      r2      = t4_ff - q2fs;
      q2c     = (r2 >= TW'(FS)) ? q2 + DW'(1) : q2;
      mag_ang = base4_ff + MW'(q2c);
      sang    = neg4_ff ? (NW'(0) - NW'(mag_ang)) : NW'(mag_ang);
      ang_in  = IS_ACOS ? (NW'(atd_pkg::HALF_PI_Q12) - sang) : sang;
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         out_ff.filt <= filt4_ff;
         out_ff.ang  <= ang_in;
      end
   end

   assign lane_out = out_ff;

endmodule

### rtl/core/atd_merge.sv
// merge stage: reference angles, wait timer, batch flag and the result register
// depends on atd_pkg
`timescale 1ns / 1ps

module atd_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  atd_pkg::lane_out_type               lane_x,
   input  atd_pkg::lane_out_type               lane_y,
   input  atd_pkg::lane_out_type               lane_z,
   input  atd_pkg::side_type                   side,
   input  atd_pkg::tilt_cfg_type               cfg,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [atd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [atd_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                out_free
);

   localparam int NW = atd_pkg::ANG_W;
   localparam int TW = atd_pkg::TIME_W;

   logic signed [NW-1:0] ref_ff [3];
   logic signed [NW-1:0] ref_in [3];
   logic signed [NW-1:0] ang    [3];
   logic                 ref_seeded_ff;
   logic                 waiting_ff;
   logic                 waiting_in;
   logic [TW-1:0]        wait_start_ff;
   logic [TW-1:0]        wait_start_in;
   logic                 batch_any_ff;
   logic                 batch_any_in;
   logic                 tilt_in;
   logic                 batch_in;
   logic                 any_out;
   logic [TW-1:0]        elapsed;
   logic                 expired;
   logic                 rsp_valid_ff;
   logic [atd_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [atd_pkg::RSP_USER_W-1:0] rsp_user_ff;

   assign ang[0] = lane_x.ang;
   assign ang[1] = lane_y.ang;
   assign ang[2] = lane_z.ang;

   always_comb begin
      logic signed [NW-1:0] ref_use [3];
      logic signed [NW:0]   dlt;
      logic [NW:0]          dmag;
      any_out = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ref_use[i] = ref_seeded_ff ? ref_ff[i] : ang[i];
         dlt        = {ang[i][NW-1], ang[i]} - {ref_use[i][NW-1], ref_use[i]};
         dmag       = dlt[NW] ? (~dlt + (NW+1)'(1)) : dlt;
         if (dmag > (NW+1)'(cfg.threshold)) begin
            any_out = 1'b1;
         end
      end

      elapsed = side.time_ms - wait_start_ff;
      expired = (side.time_ms < wait_start_ff) || (elapsed >= TW'(cfg.duration));

      tilt_in       = 1'b0;
      waiting_in    = waiting_ff;
      wait_start_in = wait_start_ff;
      if (any_out) begin
         if (waiting_ff) begin
            if (expired) begin
               waiting_in = 1'b0;
               tilt_in    = 1'b1;
            end
         end else begin
            waiting_in    = 1'b1;
            wait_start_in = side.time_ms;
         end
      end else begin
         waiting_in = 1'b0;
      end

      for (int i = 0; i < 3; i++) begin
         ref_in[i] = tilt_in ? ang[i] : ref_use[i];
      end

      batch_any_in = batch_any_ff | tilt_in;
      batch_in     = side.batch_end & batch_any_in;
      if (side.batch_end) begin
         batch_any_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         ref_seeded_ff <= 1'b0;
         waiting_ff    <= 1'b0;
         batch_any_ff  <= 1'b0;
      end else begin
         if (take) begin
            ref_seeded_ff <= 1'b1;
            waiting_ff    <= waiting_in;
            wait_start_ff <= wait_start_in;
            batch_any_ff  <= batch_any_in;
            for (int i = 0; i < 3; i++) begin
               ref_ff[i] <= ref_in[i];
            end
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {3'b0, lane_z.filt, lane_y.filt, lane_x.filt};
            rsp_user_ff  <= {batch_in, tilt_in};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/core/accel_tilt_detector_top.sv
// Accelerometer tilt detector, top level.
// Input channel req_: one three-axis sample in mg with its millisecond time
// stamp in tdata; tlast marks the last sample of a batch.
// Result channel rsp_: the three filtered axes in tdata, tilt_now and
// batch_tilt in tuser, one result item for every input item, in order.
// Configuration: csr_wen with csr_addr and csr_wdata writes filter gain,
// tilt threshold and tilt duration; write only while the block is idle.
// Path: an accepted input item passes the filter register at the accepting edge,
// five angle stages per lane and the result register before its result is valid.
// Throughput: one item per cycle unless rsp_tready stalls; three axis lanes run
// side by side and a merge stage compares their angles against the reference.
// Reset: configuration returns to its defaults, filter and reference are
// unseeded, the wait timer and batch flag clear and the pipeline empties.
// Stall: when rsp_tready is low the result register holds, empty stages
// still fill, and req_tready drops once every stage is occupied.
// depends on atd_pkg, atd_lane and atd_merge
`timescale 1ns / 1ps

module accel_tilt_detector_top #(
   parameter int MG_FULL_SCALE = atd_pkg::MG_FULL_SCALE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // accel_x, accel_y, accel_z, time_ms, zero fill
   input  logic [atd_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // filtered_x, filtered_y, filtered_z, zero fill
   output logic [atd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tilt_now, batch_tilt
   output logic [atd_pkg::RSP_USER_W-1:0]       rsp_tuser,
   input  logic                                 csr_wen,
   input  logic [atd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [atd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int LAT = atd_pkg::LANE_LAT;
   localparam int AC  = atd_pkg::ACC_W;

   logic [atd_pkg::GAIN_W-1:0] gain_ff;
   logic [atd_pkg::THR_W-1:0]  thr_ff;
   logic [atd_pkg::DUR_W-1:0]  dur_ff;
   logic                       seeded_ff;
   logic [LAT-1:0]             valid_ff;
   logic [LAT:0]               adv;
   logic [LAT-1:0]             ld;
   logic                       accept;
   logic                       take;
   logic                       out_free;
   atd_pkg::side_type          side_ff [LAT];
   atd_pkg::side_type          side_in;
   atd_pkg::tilt_cfg_type      cfg;
   atd_pkg::lane_out_type      lane_x;
   atd_pkg::lane_out_type      lane_y;
   atd_pkg::lane_out_type      lane_z;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= atd_pkg::GAIN_RESET;
         thr_ff  <= atd_pkg::THR_RESET;
         dur_ff  <= atd_pkg::DUR_RESET;
      end else if (csr_wen) begin
         unique case (atd_pkg::csr_index_type'(csr_addr))
            atd_pkg::REG_FILTER_GAIN: begin
               gain_ff <= csr_wdata[atd_pkg::GAIN_W-1:0];
            end
            atd_pkg::REG_TILT_THRESH: begin
               thr_ff <= csr_wdata[atd_pkg::THR_W-1:0];
            end
            atd_pkg::REG_TILT_DURATION: begin
               dur_ff <= csr_wdata[atd_pkg::DUR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.threshold = thr_ff;
   assign cfg.duration  = dur_ff;

   // stage advance chain, bubbles collapse
   always_comb begin
      adv[LAT] = out_free;
      for (int s = LAT - 1; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign req_tready = adv[0];
   assign accept     = req_tvalid && adv[0];
   assign take       = valid_ff[LAT-1] && adv[LAT];

   always_comb begin
      ld    = adv[LAT-1:0];
      ld[0] = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         seeded_ff <= 1'b0;
      end else begin
         if (accept) begin
            seeded_ff <= 1'b1;
         end
         if (adv[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int s = 1; s < LAT; s++) begin
            if (adv[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // time stamp and batch mark follow the lanes
   assign side_in.time_ms   = req_tdata[3*AC +: atd_pkg::TIME_W];
   assign side_in.batch_end = req_tlast;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         side_ff[0] <= side_in;
      end
      for (int s = 1; s < LAT; s++) begin
         if (ld[s]) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   atd_lane #(
      .MG_FULL_SCALE (MG_FULL_SCALE),
      .IS_ACOS       (1'b0)
   ) u_lane_x (
      .clock    (clock),
      .ld       (ld),
      .seeded   (seeded_ff),
      .gain     (gain_ff),
      .accel    ($signed(req_tdata[0 +: AC])),
      .lane_out (lane_x)
   );

   atd_lane #(
      .MG_FULL_SCALE (MG_FULL_SCALE),
      .IS_ACOS       (1'b0)
   ) u_lane_y (
      .clock    (clock),
      .ld       (ld),
      .seeded   (seeded_ff),
      .gain     (gain_ff),
      .accel    ($signed(req_tdata[AC +: AC])),
      .lane_out (lane_y)
   );

   atd_lane #(
      .MG_FULL_SCALE (MG_FULL_SCALE),
      .IS_ACOS       (1'b1)
   ) u_lane_z (
      .clock    (clock),
      .ld       (ld),
      .seeded   (seeded_ff),
      .gain     (gain_ff),
      .accel    ($signed(req_tdata[2*AC +: AC])),
      .lane_out (lane_z)
   );

   atd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .lane_x     (lane_x),
      .lane_y     (lane_y),
      .lane_z     (lane_z),
      .side       (side_ff[LAT-1]),
      .cfg        (cfg),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .out_free   (out_free)
   );

endmodule

### rtl/core/atd_checker.sv
// port-level checks for the tilt detector top level, bound to it below
// depends on atd_pkg and accel_tilt_detector_top
`timescale 1ns / 1ps

module atd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [atd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [atd_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // with the result register empty the whole pipeline can move
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // a tilt reloads the reference and clears the wait, so the next item cannot tilt
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[0] |=> !(rsp_tvalid && rsp_tuser[0]))
      else $error("tilt on two consecutive items");

endmodule

bind accel_tilt_detector_top atd_checker u_atd_checker (.*);
